FILE: sv/byte_stream_reassembler_defines.svh
// Assertion macros shared by the reassembler RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef BYTE_STREAM_REASSEMBLER_DEFINES_SVH
`define BYTE_STREAM_REASSEMBLER_DEFINES_SVH

// cons must hold in the same cycle as ante
`define BSR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsr: implication check failed");

// cons must hold in the cycle after ante
`define BSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsr: next-cycle check failed");

// cond must never be seen
`define BSR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bsr: forbidden condition seen");

`endif

FILE: sv/bsr_pkg.sv
// Shared constants and types for the byte stream reassembler.
// No dependencies; used by every RTL file of the block.
package bsr_pkg;

  localparam int CAPACITY = 64;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 32;
  localparam int BYTE_W   = 8;
  localparam int RC_W     = 7;

  localparam logic [1:0] OP_SEG_BYTE = 2'd0;
  localparam logic [1:0] OP_SEG_END  = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // set/clear requests for the hold valid map
  typedef struct packed {
    logic set_en;
    ptr_t set_idx;
    logic clr_en;
    ptr_t clr_idx;
  } valid_ctl_t;

endpackage

FILE: sv/bsr_hold_ram.sv
// Hold store for out-of-order bytes: one write port, one registered read port.
// Depends on bsr_pkg for depth and widths.
module bsr_hold_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  bsr_pkg::ptr_t             wr_addr,
  input  logic [bsr_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  bsr_pkg::ptr_t             rd_addr,
  output logic [bsr_pkg::BYTE_W-1:0] rd_data
);
  import bsr_pkg::*;

  logic [BYTE_W-1:0] mem [CAPACITY];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/bsr_valid_map.sv
// Valid bit per hold slot, cleared at reset, with two lookup ports.
// Depends on bsr_pkg for depth and the control struct.
module bsr_valid_map (
  input  logic                clk,
  input  logic                rst_n,
  input  bsr_pkg::valid_ctl_t ctl,
  input  bsr_pkg::ptr_t       chk_idx,
  output logic                chk_bit,
  input  bsr_pkg::ptr_t       scan_idx,
  output logic                scan_bit
);
  import bsr_pkg::*;

  logic [CAPACITY-1:0] valid_r;
  logic [CAPACITY-1:0] valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.clr_en) begin
      valid_nxt[ctl.clr_idx] = 1'b0;
    end
    if (ctl.set_en) begin
      valid_nxt[ctl.set_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign chk_bit  = valid_r[chk_idx];
  assign scan_bit = valid_r[scan_idx];

endmodule

FILE: sv/byte_stream_reassembler.sv
// Byte stream reassembler top level: window check, sequencer and result port.
// A plain byte is taken in idle and gives no result; a segment end scans, then releases
// its contiguous bytes (at most 64); every result shows in the cycle after the step that made it.
// One shared counter/compare walks the valid map, then the RAM read port paces release.
// Synchronous active-low reset clears positions, counts, flags and valid bits.
// Results cannot be held off; each one shows for a single cycle on out_valid.
`include "byte_stream_reassembler_defines.svh"

module byte_stream_reassembler (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic [bsr_pkg::POS_W-1:0]   in_position,
  input  logic [bsr_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                        in_segment_last,
  input  logic                        in_eof_flag,
  input  logic [bsr_pkg::RC_W-1:0]    in_read_count,
  output logic                        out_valid,
  output logic                        out_has_byte,
  output logic [bsr_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last,
  output logic                        out_stream_ended,
  output logic [bsr_pkg::CNT_W-1:0]   out_unassembled_count
);
  import bsr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_COUNT = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  ptr_t             head_r, head_nxt;
  logic [POS_W-1:0] written_r, written_nxt;
  logic [POS_W-1:0] read_r, read_nxt;
  logic [POS_W-1:0] end_pos_r, end_pos_nxt;
  logic             end_seen_r, end_seen_nxt;
  logic             ended_r, ended_nxt;
  cnt_t             held_r, held_nxt;
  cnt_t             room_r, room_nxt;
  cnt_t             cnt_r, cnt_nxt;
  logic             pend_r, pend_nxt;
  logic             plast_r, plast_nxt;
  logic             stat_r, stat_nxt;

  logic             accept;
  logic [POS_W-1:0] buf_diff;
  cnt_t             buffered;
  cnt_t             room;
  logic [POS_W-1:0] off;
  logic             in_win;
  ptr_t             slot;
  logic             chk_bit;
  logic             scan_bit;
  ptr_t             scan_idx;
  logic             scan_ok;
  logic             seg_end;
  cnt_t             rd_clamp;
  logic [RC_W-1:0]  rc_lim;
  logic [POS_W-1:0] wr_sum;
  valid_ctl_t       vctl;
  logic             ram_wr_en;
  logic             ram_rd_en;
  logic [BYTE_W-1:0] ram_rd_data;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // bytes written but not yet consumed; never above the capacity
  assign buf_diff = written_r - read_r;
  assign buffered = buf_diff[CNT_W-1:0];
  assign room     = CNT_W'(CAPACITY) - buffered;

  assign off    = in_position - written_r;
  assign in_win = off < POS_W'(room);
  assign slot   = head_r + off[PTR_W-1:0];

  assign seg_end = (in_op == OP_SEG_END) || ((in_op == OP_SEG_BYTE) && in_segment_last);

  assign rc_lim   = RC_W'(buffered);
  assign rd_clamp = (in_read_count > rc_lim) ? CNT_W'(rc_lim) : CNT_W'(in_read_count);

  // scan contiguous held bytes from the head, bounded by output room
  assign scan_idx = head_r + cnt_r[PTR_W-1:0];
  assign scan_ok  = (cnt_r < room_r) && scan_bit;
  assign wr_sum   = written_r + POS_W'(cnt_r);

  assign ram_wr_en = accept && (in_op == OP_SEG_BYTE) && in_win && !chk_bit;
  assign ram_rd_en = (state_r == ST_EMIT);

  always_comb begin
    vctl.set_en  = ram_wr_en;
    vctl.set_idx = slot;
    vctl.clr_en  = ram_rd_en;
    vctl.clr_idx = head_r;
  end

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    written_nxt  = written_r;
    read_nxt     = read_r;
    end_pos_nxt  = end_pos_r;
    end_seen_nxt = end_seen_r;
    ended_nxt    = ended_r;
    held_nxt     = held_r;
    room_nxt     = room_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = 1'b0;
    plast_nxt    = plast_r;
    stat_nxt     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_READ: begin
              read_nxt = read_r + POS_W'(rd_clamp);
              stat_nxt = 1'b1;
            end
            OP_SEG_BYTE, OP_SEG_END: begin
              if (ram_wr_en) begin
                held_nxt = held_r + 1'b1;
              end
              if (seg_end) begin
                if (in_eof_flag) begin
                  end_seen_nxt = 1'b1;
                  end_pos_nxt  = in_position + POS_W'(in_op == OP_SEG_BYTE);
                end
                room_nxt  = room;
                cnt_nxt   = '0;
                state_nxt = ST_COUNT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_COUNT: begin
        if (scan_ok) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          written_nxt = wr_sum;
          held_nxt    = held_r - cnt_r;
          ended_nxt   = ended_r || (end_seen_r && (end_pos_r == wr_sum));
          if (cnt_r == '0) begin
            stat_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        head_nxt  = head_r + 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        pend_nxt  = 1'b1;
        plast_nxt = (cnt_r == CNT_W'(1));
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      head_r     <= '0;
      written_r  <= '0;
      read_r     <= '0;
      end_pos_r  <= '0;
      end_seen_r <= 1'b0;
      ended_r    <= 1'b0;
      held_r     <= '0;
      room_r     <= '0;
      cnt_r      <= '0;
      pend_r     <= 1'b0;
      stat_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      written_r  <= written_nxt;
      read_r     <= read_nxt;
      end_pos_r  <= end_pos_nxt;
      end_seen_r <= end_seen_nxt;
      ended_r    <= ended_nxt;
      held_r     <= held_nxt;
      room_r     <= room_nxt;
      cnt_r      <= cnt_nxt;
      pend_r     <= pend_nxt;
      stat_r     <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plast_r <= plast_nxt;
  end

  bsr_valid_map u_valid (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (vctl),
    .chk_idx  (slot),
    .chk_bit  (chk_bit),
    .scan_idx (scan_idx),
    .scan_bit (scan_bit)
  );

  bsr_hold_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (slot),
    .wr_data (in_data_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (head_r),
    .rd_data (ram_rd_data)
  );

  // flags and count are already final for the item when its results show
  assign out_valid             = pend_r || stat_r;
  assign out_has_byte          = pend_r;
  assign out_byte              = pend_r ? ram_rd_data : '0;
  assign out_last              = pend_r ? plast_r : stat_r;
  assign out_stream_ended      = ended_r;
  assign out_unassembled_count = held_r;

  `BSR_ASSERT_NEVER(a_out_excl, pend_r && stat_r)
  `BSR_ASSERT_NEVER(a_held_cap, held_r > CNT_W'(CAPACITY))
  `BSR_ASSERT_NEVER(a_buf_cap, (written_r - read_r) > POS_W'(CAPACITY))
  `BSR_ASSERT_NEXT(a_emit_strobe, state_r == ST_EMIT, out_valid && out_has_byte)
  `BSR_ASSERT_IMPL(a_count_quiet, state_r == ST_COUNT, !out_has_byte)

endmodule
